[rtl/kti_pkg.sv]
package kti_pkg;

  localparam int MAX_KEYS   = 64;
  localparam int MAX_TRACKS = 16;
  localparam int KEY_AW     = $clog2(MAX_KEYS);
  localparam int KEY_CNT_W  = KEY_AW + 1;
  localparam int TRK_AW     = $clog2(MAX_TRACKS);
  localparam int MEM_DEPTH  = MAX_KEYS * MAX_TRACKS;
  localparam int MEM_AW     = KEY_AW + TRK_AW;

  localparam int TIME_W     = 32;
  localparam int VAL_W      = 32;
  localparam int VEC_W      = 4 * VAL_W;

  localparam int FRAC_BITS  = 16;
  localparam int IQ         = 30;
  localparam int CORDIC_STEPS = 30;
  localparam logic [31:0] CORDIC_GAIN = 32'd652032874;

  // divider lengths: fraction, slerp weight, normalisation (32 magnitude bits + 15)
  localparam int DIV_FRAC_STEPS = FRAC_BITS;
  localparam int DIV_WGT_STEPS  = IQ;
  localparam int DIV_NORM_STEPS = VAL_W + 15;
  localparam int DIV_QW         = DIV_NORM_STEPS;

  localparam logic [1:0] OP_SET_TRACK = 2'd0;
  localparam logic [1:0] OP_WRITE_KEY = 2'd1;
  localparam logic [1:0] OP_QUERY     = 2'd2;

  // arctan(2^-i) in Q2.30
  function automatic logic [31:0] atan_tab(input logic [4:0] i);
    logic [31:0] v;
    unique case (i)
      5'd0:  v = 32'h3243F6A8;
      5'd1:  v = 32'h1DAC6705;
      5'd2:  v = 32'h0FADBAFC;
      5'd3:  v = 32'h07F56EA6;
      5'd4:  v = 32'h03FEAB76;
      5'd5:  v = 32'h01FFD55B;
      5'd6:  v = 32'h00FFFAAA;
      5'd7:  v = 32'h007FFF55;
      5'd8:  v = 32'h003FFFEA;
      5'd9:  v = 32'h001FFFFD;
      5'd10: v = 32'h000FFFFF;
      5'd11: v = 32'h0007FFFF;
      5'd12: v = 32'h0003FFFF;
      5'd13: v = 32'h0001FFFF;
      5'd14: v = 32'h0000FFFF;
      5'd15: v = 32'h00007FFF;
      5'd16: v = 32'h00003FFF;
      5'd17: v = 32'h00001FFF;
      5'd18: v = 32'h00000FFF;
      5'd19: v = 32'h000007FF;
      5'd20: v = 32'h000003FF;
      5'd21: v = 32'h000001FF;
      5'd22: v = 32'h000000FF;
      5'd23: v = 32'h0000007F;
      5'd24: v = 32'h0000003F;
      5'd25: v = 32'h0000001F;
      5'd26: v = 32'h0000000F;
      5'd27: v = 32'h00000008;
      5'd28: v = 32'h00000004;
      5'd29: v = 32'h00000002;
      default: v = 32'h00000000;
    endcase
    return v;
  endfunction

endpackage

[rtl/kti_ram.sv]
module kti_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[rtl/keyframe_track_interpolator.sv]
// channel    | ports                                             | transfer when
// -----------+---------------------------------------------------+-------------------
// command in | start, op, track, key_index, key_count,           | start high, busy low
//            | is_quaternion, key_time, value_x..value_w,        |
//            | query_time                                        |
// result out | done, out_x, out_y, out_z, out_w, out_size        | done high, one cycle
//
// ops 0 and 1 leave busy low, so a command can follow at once
// a query searches the keys in order for the first one later than query_time, then
// returns the first or last key as it stands, lerps a vector track, or blends a quaternion
// track by slerp or a normalised-lerp fallback (shared serial divider, square root, cordic)
// rst is synchronous; it clears the track descriptors, key memories need writing first
// the receiver cannot stall: done is high for exactly one cycle, the outputs hold until the next result

module keyframe_track_interpolator (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               start,
  output logic                               busy,
  input  logic [1:0]                         op,
  input  logic [kti_pkg::TRK_AW-1:0]         track,
  input  logic [kti_pkg::KEY_AW-1:0]         key_index,
  input  logic [kti_pkg::KEY_CNT_W-1:0]      key_count,
  input  logic                               is_quaternion,
  input  logic [kti_pkg::TIME_W-1:0]         key_time,
  input  logic signed [kti_pkg::VAL_W-1:0]   value_x,
  input  logic signed [kti_pkg::VAL_W-1:0]   value_y,
  input  logic signed [kti_pkg::VAL_W-1:0]   value_z,
  input  logic signed [kti_pkg::VAL_W-1:0]   value_w,
  input  logic [kti_pkg::TIME_W-1:0]         query_time,
  output logic                               done,
  output logic signed [kti_pkg::VAL_W-1:0]   out_x,
  output logic signed [kti_pkg::VAL_W-1:0]   out_y,
  output logic signed [kti_pkg::VAL_W-1:0]   out_z,
  output logic signed [kti_pkg::VAL_W-1:0]   out_w,
  output logic [2:0]                         out_size
);

  localparam int NS = 29;
  localparam int CW = 36;   // cordic datapath, angles and vectors stay well under 2^33
  localparam int MW = 33;   // multiplier operand width

  typedef enum logic [NS-1:0] {
    S_IDLE     = 29'b1 << 0,
    S_SRCH_RD  = 29'b1 << 1,
    S_SRCH_CMP = 29'b1 << 2,
    S_SEL      = 29'b1 << 3,
    S_END_RD   = 29'b1 << 4,
    S_RD_A     = 29'b1 << 5,
    S_RD_B     = 29'b1 << 6,
    S_DIV      = 29'b1 << 7,
    S_FRAC     = 29'b1 << 8,
    S_LERP_M   = 29'b1 << 9,
    S_LERP_A   = 29'b1 << 10,
    S_DOT_M    = 29'b1 << 11,
    S_DOT_A    = 29'b1 << 12,
    S_AC       = 29'b1 << 13,
    S_REM      = 29'b1 << 14,
    S_SQRT     = 29'b1 << 15,
    S_CORD     = 29'b1 << 16,
    S_TH_M     = 29'b1 << 17,
    S_TH_A     = 29'b1 << 18,
    S_SIN_CHK  = 29'b1 << 19,
    S_WT       = 29'b1 << 20,
    S_BL_M     = 29'b1 << 21,
    S_BL_N     = 29'b1 << 22,
    S_BL_A     = 29'b1 << 23,
    S_N2_M     = 29'b1 << 24,
    S_N2_A     = 29'b1 << 25,
    S_NORM     = 29'b1 << 26,
    S_NORM_A   = 29'b1 << 27,
    S_OUT      = 29'b1 << 28
  } state_t;

  localparam logic signed [31:0] ONE_W   = 32'sd1 << kti_pkg::IQ;
  localparam logic signed [63:0] ONE_64  = 64'sd1 << kti_pkg::IQ;
  localparam logic        [63:0] ONE_SQ  = 64'd1 << (2 * kti_pkg::IQ);
  localparam logic signed [63:0] HALF_IQ = 64'sd1 << (kti_pkg::IQ - 1);
  localparam logic signed [63:0] HALF_FB = 64'sd1 << (kti_pkg::FRAC_BITS - 1);
  localparam logic signed [63:0] SAT_MAX = 64'sd2147483647;
  localparam logic signed [63:0] SAT_MIN = -64'sd2147483648;

  state_t state;
  state_t div_ret;

  // track descriptors
  logic [kti_pkg::KEY_CNT_W-1:0] key_total [kti_pkg::MAX_TRACKS];
  logic                          quat_flag [kti_pkg::MAX_TRACKS];

  // query context
  logic [kti_pkg::TRK_AW-1:0]    trk;
  logic [kti_pkg::TIME_W-1:0]    qt;
  logic [kti_pkg::KEY_CNT_W-1:0] cnt;
  logic                          quat;
  logic [kti_pkg::KEY_CNT_W-1:0] idx;
  logic [kti_pkg::TIME_W-1:0]    t1;
  logic signed [31:0]            a [4];
  logic signed [31:0]            b [4];
  logic signed [31:0]            res [4];
  logic [1:0]                    k;
  logic [kti_pkg::FRAC_BITS-1:0] ffb;

  // shared multiplier
  logic signed [MW-1:0]          opa, opb;
  logic signed [2*MW-1:0]        prod_full;
  logic signed [63:0]            prod;
  logic signed [63:0]            acc;

  // slerp state
  logic signed [63:0]            dot;
  logic [kti_pkg::IQ-1:0]        ac;
  logic [31:0]                   sinv;
  logic [31:0]                   nn;
  logic signed [CW-1:0]          len;
  logic                          ph;
  logic                          fb;
  logic                          norm;
  logic signed [31:0]            w_s, w_t;
  logic [63:0]                   n2;

  // serial divider
  logic [31:0]                   div_r, div_den, div_n;
  logic [kti_pkg::DIV_QW-1:0]    div_q;
  logic [5:0]                    div_cnt;

  // serial square root
  logic [63:0]                   sq_n, sq_r;
  logic [4:0]                    sq_j;

  // cordic
  logic signed [CW-1:0]          cx, cy, cz;
  logic [4:0]                    ci;
  logic                          c_atan;

  // memories
  logic                          mem_we;
  logic [kti_pkg::MEM_AW-1:0]    mem_waddr;
  logic [kti_pkg::MEM_AW-1:0]    t_raddr, v_raddr;
  logic [kti_pkg::TIME_W-1:0]    t_rdata;
  logic [kti_pkg::VEC_W-1:0]     v_rdata;

  assign busy = (state != S_IDLE);

  assign mem_we    = start && !busy && (op == kti_pkg::OP_WRITE_KEY);
  assign mem_waddr = {track, key_index};

  kti_ram #(.WIDTH(kti_pkg::TIME_W), .DEPTH(kti_pkg::MEM_DEPTH)) u_times (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (key_time),
    .raddr (t_raddr),
    .rdata (t_rdata)
  );

  kti_ram #(.WIDTH(kti_pkg::VEC_W), .DEPTH(kti_pkg::MEM_DEPTH)) u_values (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata ({value_w, value_z, value_y, value_x}),
    .raddr (v_raddr),
    .rdata (v_rdata)
  );

  // small helpers
  logic [kti_pkg::KEY_AW-1:0] idx_lo, idx_m1, cnt_m1;
  assign idx_lo = idx[kti_pkg::KEY_AW-1:0];
  assign idx_m1 = idx_lo - 1'b1;
  assign cnt_m1 = cnt[kti_pkg::KEY_AW-1:0] - 1'b1;

  logic        first_key;
  logic        past_end;
  assign first_key = (cnt <= 1) || (idx == '0);
  assign past_end  = (idx >= cnt);

  // read address steering
  always_comb begin
    t_raddr = '0;
    v_raddr = '0;
    unique case (state)
      S_SRCH_RD: t_raddr = {trk, idx_lo};
      S_SEL: begin
        t_raddr = {trk, idx_m1};
        priority if (first_key) v_raddr = {trk, {kti_pkg::KEY_AW{1'b0}}};
        else if (past_end)      v_raddr = {trk, cnt_m1};
        else                    v_raddr = {trk, idx_m1};
      end
      S_RD_A:  v_raddr = {trk, idx_lo};
      default: ;
    endcase
  end

  // fraction in Q2.30 and its complement
  logic signed [MW-1:0] f_q, omf_q;
  assign f_q   = MW'(ffb) <<< (kti_pkg::IQ - kti_pkg::FRAC_BITS);
  assign omf_q = MW'(ONE_W) - f_q;

  logic signed [63:0] ac_c;
  assign ac_c = dot[63] ? -dot : dot;

  logic signed [31:0] t_eff;
  assign t_eff = dot[63] ? -w_t : w_t;

  // multiplier operand selection
  always_comb begin
    opa = '0;
    opb = '0;
    unique case (state)
      S_LERP_M: begin
        opa = MW'(b[k]) - MW'(a[k]);
        opb = MW'(ffb);
      end
      S_DOT_M: begin
        opa = MW'(a[k]);
        opb = MW'(b[k]);
      end
      S_AC: begin
        opa = MW'(ac_c[kti_pkg::IQ-1:0]);
        opb = MW'(ac_c[kti_pkg::IQ-1:0]);
      end
      S_TH_M: begin
        opa = ph ? f_q : omf_q;
        opb = MW'(len);
      end
      S_BL_M: begin
        opa = MW'(a[k]);
        opb = MW'(w_s);
      end
      S_BL_N: begin
        opa = MW'(b[k]);
        opb = MW'(t_eff);
      end
      S_N2_M: begin
        opa = MW'(res[k]);
        opb = MW'(res[k]);
      end
      default: ;
    endcase
  end

  assign prod_full = opa * opb;

  // divider step
  logic [32:0] div_sh;
  logic        div_ge;
  logic [31:0] div_r_next;
  assign div_sh     = {div_r, div_n[31]};
  assign div_ge     = div_sh >= {1'b0, div_den};
  assign div_r_next = div_ge ? 32'(div_sh - {1'b0, div_den}) : div_sh[31:0];

  // square root step
  logic [63:0] sq_bit, sq_try, sq_n_next, sq_r_next;
  always_comb begin
    sq_bit = 64'd1 << {sq_j, 1'b0};
    sq_try = sq_r + sq_bit;
    if (sq_n >= sq_try) begin
      sq_n_next = sq_n - sq_try;
      sq_r_next = (sq_r >> 1) + sq_bit;
    end else begin
      sq_n_next = sq_n;
      sq_r_next = sq_r >> 1;
    end
  end

  // cordic step, vectoring for atan and rotation for sin
  logic signed [CW-1:0] c_dx, c_dy, c_tab, cx_next, cy_next, cz_next;
  logic                 c_up;
  always_comb begin
    c_dx  = cy >>> ci;
    c_dy  = cx >>> ci;
    c_tab = CW'(kti_pkg::atan_tab(ci));
    c_up  = c_atan ? (cy > 0) : (cz >= 0);
    if (c_atan == c_up) begin
      cx_next = cx + c_dx;
      cy_next = cy - c_dy;
    end else begin
      cx_next = cx - c_dx;
      cy_next = cy + c_dy;
    end
    cz_next = (c_atan == c_up) ? cz + c_tab : cz - c_tab;
    if (!c_atan) begin
      cz_next = c_up ? cz - c_tab : cz + c_tab;
    end
  end

  // blend rounding and saturation
  logic signed [63:0] bl_sum, bl_rnd;
  logic signed [31:0] bl_sat;
  always_comb begin
    bl_sum = acc + prod;
    bl_rnd = (bl_sum + HALF_IQ) >>> kti_pkg::IQ;
    priority if (bl_rnd > SAT_MAX) bl_sat = 32'sh7FFFFFFF;
    else if (bl_rnd < SAT_MIN)     bl_sat = 32'sh80000000;
    else                           bl_sat = bl_rnd[31:0];
  end

  logic signed [63:0] lp_rnd;
  assign lp_rnd = (prod + HALF_FB) >>> kti_pkg::FRAC_BITS;

  // normalisation magnitude and signed saturation of the quotient
  logic [31:0]        nrm_mag;
  logic signed [31:0] nrm_val;
  assign nrm_mag = res[k][31] ? 32'(-33'(res[k])) : res[k];
  always_comb begin
    if (!res[k][31]) begin
      nrm_val = (div_q > kti_pkg::DIV_QW'(SAT_MAX)) ? 32'sh7FFFFFFF : div_q[31:0];
    end else begin
      nrm_val = (div_q >= kti_pkg::DIV_QW'(64'd2147483648)) ? 32'sh80000000
                                                            : 32'(-div_q[31:0]);
    end
  end

  logic [63:0] rem_c;
  assign rem_c = ONE_SQ - prod;

  logic signed [CW-1:0] sinv_c;
  assign sinv_c = CW'({1'b0, sinv});

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      done  <= 1'b0;
      for (int i = 0; i < kti_pkg::MAX_TRACKS; i++) begin
        key_total[i] <= '0;
        quat_flag[i] <= 1'b0;
      end
    end else begin
      done <= 1'b0;
      prod <= prod_full[63:0];
      unique case (state)
        S_IDLE: begin
          if (start) begin
            if (op == kti_pkg::OP_SET_TRACK) begin
              key_total[track] <= (key_count > kti_pkg::KEY_CNT_W'(kti_pkg::MAX_KEYS))
                                  ? kti_pkg::KEY_CNT_W'(kti_pkg::MAX_KEYS) : key_count;
              quat_flag[track] <= is_quaternion;
            end else if (op == kti_pkg::OP_QUERY) begin
              trk   <= track;
              qt    <= query_time;
              cnt   <= key_total[track];
              quat  <= quat_flag[track];
              idx   <= '0;
              state <= S_SRCH_RD;
            end
          end
        end

        // linear search for the first key later than the query time
        S_SRCH_RD: state <= past_end ? S_SEL : S_SRCH_CMP;
        S_SRCH_CMP: begin
          if (t_rdata > qt) begin
            t1    <= t_rdata;
            state <= S_SEL;
          end else begin
            idx   <= idx + 1'b1;
            state <= S_SRCH_RD;
          end
        end

        S_SEL: state <= (first_key || past_end) ? S_END_RD : S_RD_A;

        S_END_RD: begin
          for (int i = 0; i < 4; i++) res[i] <= v_rdata[32*i +: 32];
          state <= S_OUT;
        end

        // earlier key arrives, fraction division set up
        S_RD_A: begin
          for (int i = 0; i < 4; i++) a[i] <= v_rdata[32*i +: 32];
          div_r   <= qt - t_rdata;
          div_den <= t1 - t_rdata;
          div_n   <= '0;
          div_q   <= '0;
          div_cnt <= 6'(kti_pkg::DIV_FRAC_STEPS);
          div_ret <= S_FRAC;
          state   <= S_RD_B;
        end
        S_RD_B: begin
          for (int i = 0; i < 4; i++) b[i] <= v_rdata[32*i +: 32];
          state <= S_DIV;
        end

        S_DIV: begin
          div_r   <= div_r_next;
          div_n   <= div_n << 1;
          div_q   <= {div_q[kti_pkg::DIV_QW-2:0], div_ge};
          div_cnt <= div_cnt - 1'b1;
          if (div_cnt == 6'd1) state <= div_ret;
        end

        S_FRAC: begin
          ffb <= div_q[kti_pkg::FRAC_BITS-1:0];
          k   <= '0;
          dot <= '0;
          priority if (!quat) begin
            state <= S_LERP_M;
          end else if (div_q[kti_pkg::FRAC_BITS-1:0] == '0 ||
                       (a[0] == b[0] && a[1] == b[1] && a[2] == b[2] && a[3] == b[3])) begin
            // exact start or identical keys
            for (int i = 0; i < 4; i++) res[i] <= a[i];
            state <= S_OUT;
          end else begin
            state <= S_DOT_M;
          end
        end

        S_LERP_M: state <= S_LERP_A;
        S_LERP_A: begin
          res[k] <= a[k] + lp_rnd[31:0];
          k      <= k + 1'b1;
          state  <= (k == 2'd2) ? S_OUT : S_LERP_M;
        end

        S_DOT_M: state <= S_DOT_A;
        S_DOT_A: begin
          dot   <= dot + (prod >>> 2);
          k     <= k + 1'b1;
          state <= (k == 2'd3) ? S_AC : S_DOT_M;
        end

        S_AC: begin
          ac <= ac_c[kti_pkg::IQ-1:0];
          if (ac_c < ONE_64) begin
            state <= S_REM;
          end else begin
            fb    <= 1'b1;
            w_s   <= 32'(omf_q);
            w_t   <= 32'(f_q);
            k     <= '0;
            state <= S_BL_M;
          end
        end

        // slerp only when 1 - cos^2 is at least one output lsb
        S_REM: begin
          if (rem_c[63:2*kti_pkg::IQ-kti_pkg::FRAC_BITS] != '0) begin
            fb    <= 1'b0;
            norm  <= 1'b0;
            sq_n  <= rem_c;
            sq_r  <= '0;
            sq_j  <= 5'd31;
            state <= S_SQRT;
          end else begin
            fb    <= 1'b1;
            w_s   <= 32'(omf_q);
            w_t   <= 32'(f_q);
            k     <= '0;
            state <= S_BL_M;
          end
        end

        S_SQRT: begin
          sq_n <= sq_n_next;
          sq_r <= sq_r_next;
          sq_j <= sq_j - 1'b1;
          if (sq_j == '0) begin
            if (norm) begin
              nn    <= sq_r_next[31:0];
              k     <= '0;
              state <= S_NORM;
            end else begin
              sinv   <= sq_r_next[31:0];
              cx     <= CW'({1'b0, ac});
              cy     <= CW'({1'b0, sq_r_next[31:0]});
              cz     <= '0;
              ci     <= '0;
              c_atan <= 1'b1;
              state  <= S_CORD;
            end
          end
        end

        S_CORD: begin
          cx <= cx_next;
          cy <= cy_next;
          cz <= cz_next;
          ci <= ci + 1'b1;
          if (ci == 5'(kti_pkg::CORDIC_STEPS - 1)) begin
            if (c_atan) begin
              len   <= cz_next;
              ph    <= 1'b0;
              state <= S_TH_M;
            end else begin
              state <= S_SIN_CHK;
            end
          end
        end

        S_TH_M: state <= S_TH_A;
        S_TH_A: begin
          cx     <= CW'({1'b0, kti_pkg::CORDIC_GAIN});
          cy     <= '0;
          cz     <= CW'(prod >>> kti_pkg::IQ);
          ci     <= '0;
          c_atan <= 1'b0;
          state  <= S_CORD;
        end

        // weight = clamp(sin(theta) / sin(angle), 0, 1)
        S_SIN_CHK: begin
          if (cy > 0 && cy < sinv_c) begin
            div_r   <= cy[31:0];
            div_den <= sinv;
            div_n   <= '0;
            div_q   <= '0;
            div_cnt <= 6'(kti_pkg::DIV_WGT_STEPS);
            div_ret <= S_WT;
            state   <= S_DIV;
          end else if (!ph) begin
            w_s   <= (cy > 0) ? ONE_W : '0;
            ph    <= 1'b1;
            state <= S_TH_M;
          end else begin
            w_t   <= (cy > 0) ? ONE_W : '0;
            k     <= '0;
            state <= S_BL_M;
          end
        end

        S_WT: begin
          if (!ph) begin
            w_s   <= 32'(div_q[kti_pkg::IQ-1:0]);
            ph    <= 1'b1;
            state <= S_TH_M;
          end else begin
            w_t   <= 32'(div_q[kti_pkg::IQ-1:0]);
            k     <= '0;
            state <= S_BL_M;
          end
        end

        S_BL_M: state <= S_BL_N;
        S_BL_N: begin
          acc   <= prod;
          state <= S_BL_A;
        end
        S_BL_A: begin
          res[k] <= bl_sat;
          k      <= k + 1'b1;
          if (k != 2'd3) begin
            state <= S_BL_M;
          end else if (fb) begin
            n2    <= '0;
            state <= S_N2_M;
          end else begin
            state <= S_OUT;
          end
        end

        S_N2_M: state <= S_N2_A;
        S_N2_A: begin
          n2 <= n2 + {2'b00, prod[63:2]};
          k  <= k + 1'b1;
          if (k == 2'd3) begin
            sq_n  <= n2 + {2'b00, prod[63:2]};
            sq_r  <= '0;
            sq_j  <= 5'd31;
            norm  <= 1'b1;
            state <= S_SQRT;
          end else begin
            state <= S_N2_M;
          end
        end

        S_NORM: begin
          if (nn == '0) begin
            // zero-length blend gives all zeros
            for (int i = 0; i < 4; i++) res[i] <= '0;
            state <= S_OUT;
          end else begin
            div_r   <= '0;
            div_den <= nn;
            div_n   <= nrm_mag;
            div_q   <= '0;
            div_cnt <= 6'(kti_pkg::DIV_NORM_STEPS);
            div_ret <= S_NORM_A;
            state   <= S_DIV;
          end
        end
        S_NORM_A: begin
          res[k] <= nrm_val;
          k      <= k + 1'b1;
          state  <= (k == 2'd3) ? S_OUT : S_NORM;
        end

        S_OUT: begin
          out_x    <= res[0];
          out_y    <= res[1];
          out_z    <= res[2];
          out_w    <= quat ? res[3] : '0;
          out_size <= quat ? 3'd4 : 3'd3;
          done     <= 1'b1;
          state    <= S_IDLE;
        end

        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
